### src/erot_pkg.sv
// ----------------------------------------------------------------------------
// erot_pkg: shared types and constants of the Euler point rotator
// Coordinate and angle formats, CORDIC constants, the arctangent table and
// the transaction and pipeline structures handed from cell to cell.
// ----------------------------------------------------------------------------
package erot_pkg;

  // Widths of the transaction fields
  localparam int unsigned COORD_WIDTH      = 24;
  localparam int unsigned ANGLE_W          = 19;
  localparam int unsigned ANGLE_FRAC       = 16;

  // CORDIC depth: one cell per micro-rotation
  localparam int unsigned ANGLE_ITERATIONS = 16;
  localparam int unsigned TABLE_LEN        = 24;
  localparam int unsigned CORDIC_STEPS     =
      (ANGLE_ITERATIONS < TABLE_LEN) ? ANGLE_ITERATIONS : TABLE_LEN;
  localparam int unsigned STEP_W           = $clog2(TABLE_LEN);

  // Internal number formats
  localparam int unsigned CORDIC_FRAC      = 30;
  localparam int unsigned SC_FRAC          = 24;
  localparam int unsigned C_W              = 34;
  localparam int unsigned SC_W             = SC_FRAC + 2;
  localparam int unsigned PT_W             = COORD_WIDTH + 3;
  localparam int unsigned PROD_W           = SC_W + PT_W;
  localparam int unsigned SUM_W            = PROD_W + 1;

  // Configuration port
  localparam int unsigned CFG_IW           = 3;
  localparam int unsigned CFG_DW           =
      (COORD_WIDTH > ANGLE_W) ? COORD_WIDTH : ANGLE_W;

  // Register stages from input to output register
  localparam int unsigned PIPE_DEPTH       = 2 + CORDIC_STEPS + 3 * 3 + 1;

  // Angle constants in Q30
  localparam logic signed [C_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [C_W-1:0] TWO_PI_Q30  = 34'sd6746518852;
  localparam logic signed [C_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [C_W-1:0] GAIN_Q30    = 34'sd652032874;

  // atan(2^-i) in Q30, truncated
  localparam logic [29:0] ATAN_Q30 [TABLE_LEN] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
    30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
    30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
    30'd262143,    30'd131071,    30'd65535,     30'd32767,
    30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127
  };

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [ANGLE_W-1:0]     angle_t;
  typedef logic signed [PT_W-1:0]        pt_t;

  // Register reset values
  localparam angle_t ANGLE_X_RST = angle_t'(1311);
  localparam angle_t ANGLE_Y_RST = angle_t'(655);
  localparam angle_t ANGLE_Z_RST = angle_t'(2621);
  localparam coord_t CENTER_RST  = coord_t'(38400);

  typedef enum logic [CFG_IW-1:0] {
    REG_ANGLE_X,
    REG_ANGLE_Y,
    REG_ANGLE_Z,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z
  } cfg_reg_e;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef struct packed {
    coord_t in_x;
    coord_t in_y;
    coord_t in_z;
  } in_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
  } out_t;

  typedef struct packed {
    angle_t angle_x;
    angle_t angle_y;
    angle_t angle_z;
    coord_t center_x;
    coord_t center_y;
    coord_t center_z;
  } cfg_t;

  // One CORDIC lane: cosine, sine, residual angle and the fold flag
  typedef struct packed {
    logic signed [C_W-1:0] x;
    logic signed [C_W-1:0] y;
    logic signed [C_W-1:0] z;
    logic                  neg;
  } lane_t;

  // Everything one point carries along the chain
  typedef struct packed {
    pt_t   [2:0] p;
    lane_t [2:0] lane;
  } pipe_t;

endpackage

### src/euler_point_rotator_unit.sv
// ----------------------------------------------------------------------------
// euler_point_rotator_unit: 3D point rotation about a configurable centre
// Subtract the centre, rotate about X, then Y, then Z with CORDIC-derived
// sine and cosine, add the centre back and saturate.
//
//   channel | signals                               | transaction
//   --------+---------------------------------------+---------------------
//   in      | in_valid_i, in_ready_o, in_data_i     | one point (in_t)
//   out     | out_valid_o, out_ready_i, out_data_o  | one point (out_t)
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,| one register write
//           | cfg_data_i                            |
//
// One point enters per cycle unless stalled; PIPE_DEPTH stages (2 entry cells,
// one cell per CORDIC step, 3 cells per axis rotation, 1 output cell; 28 at
// 16 steps). Each cell advances as soon as its successor frees, so bubbles
// close up and input is taken while the output register holds a result.
// Reset clears all valid flags and loads the register reset values. Writes
// on cfg are taken every cycle and must only happen while the unit is empty.
// ----------------------------------------------------------------------------
module euler_point_rotator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  erot_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output erot_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [erot_pkg::CFG_IW-1:0]   cfg_index_i,
  input  logic [erot_pkg::CFG_DW-1:0]   cfg_data_i
);
  import erot_pkg::*;

  cfg_t  cfg_q;

  logic  cord_valid [CORDIC_STEPS+1];
  logic  cord_ready [CORDIC_STEPS+1];
  pipe_t cord_data  [CORDIC_STEPS+1];

  logic  rot_valid  [4];
  logic  rot_ready  [4];
  pipe_t rot_data   [4];

  // Register writes, indexes beyond the list are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_x  <= ANGLE_X_RST;
      cfg_q.angle_y  <= ANGLE_Y_RST;
      cfg_q.angle_z  <= ANGLE_Z_RST;
      cfg_q.center_x <= CENTER_RST;
      cfg_q.center_y <= CENTER_RST;
      cfg_q.center_z <= CENTER_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ANGLE_X:  cfg_q.angle_x  <= cfg_data_i[ANGLE_W-1:0];
        REG_ANGLE_Y:  cfg_q.angle_y  <= cfg_data_i[ANGLE_W-1:0];
        REG_ANGLE_Z:  cfg_q.angle_z  <= cfg_data_i[ANGLE_W-1:0];
        REG_CENTER_X: cfg_q.center_x <= cfg_data_i[COORD_WIDTH-1:0];
        REG_CENTER_Y: cfg_q.center_y <= cfg_data_i[COORD_WIDTH-1:0];
        REG_CENTER_Z: cfg_q.center_z <= cfg_data_i[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Entry cells
  erot_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .cfg_i   (cfg_q),
    .valid_o (cord_valid[0]),
    .ready_i (cord_ready[0]),
    .data_o  (cord_data[0])
  );

  // CORDIC chain, one cell per step
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    erot_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (STEP_W'(g)),
      .valid_i (cord_valid[g]),
      .ready_o (cord_ready[g]),
      .data_i  (cord_data[g]),
      .valid_o (cord_valid[g+1]),
      .ready_i (cord_ready[g+1]),
      .data_o  (cord_data[g+1])
    );
  end

  assign rot_valid[0]               = cord_valid[CORDIC_STEPS];
  assign rot_data[0]                = cord_data[CORDIC_STEPS];
  assign cord_ready[CORDIC_STEPS]   = rot_ready[0];

  // Rotations about X, Y and Z in turn
  for (genvar g = 0; g < 3; g++) begin : g_rotate
    erot_rotate_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .axis_i  (axis_e'(g)),
      .valid_i (rot_valid[g]),
      .ready_o (rot_ready[g]),
      .data_i  (rot_data[g]),
      .valid_o (rot_valid[g+1]),
      .ready_i (rot_ready[g+1]),
      .data_o  (rot_data[g+1])
    );
  end

  // Output cell
  erot_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (rot_valid[3]),
    .ready_o (rot_ready[3]),
    .data_i  (rot_data[3]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

### src/erot_prep.sv
// ----------------------------------------------------------------------------
// erot_prep: entry cells of the rotator
// Subtract the centre and wrap each angle into [-pi, pi], then fold each
// angle into [-pi/2, pi/2] and seed the three CORDIC lanes.
// ----------------------------------------------------------------------------
module erot_prep (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  erot_pkg::in_t  data_i,
  input  erot_pkg::cfg_t cfg_i,
  output logic           valid_o,
  input  logic           ready_i,
  output erot_pkg::pipe_t data_o
);
  import erot_pkg::*;

  logic  v1_q, v2_q;
  logic  rdy1, rdy2;
  pipe_t pipe1_d, pipe1_q;
  pipe_t pipe2_d, pipe2_q;

  // Centre subtraction and angle wrap
  always_comb begin
    angle_t                ang [3];
    coord_t                pin [3];
    coord_t                cen [3];
    logic signed [C_W-1:0] z0;
    ang = '{cfg_i.angle_x, cfg_i.angle_y, cfg_i.angle_z};
    pin = '{data_i.in_x, data_i.in_y, data_i.in_z};
    cen = '{cfg_i.center_x, cfg_i.center_y, cfg_i.center_z};
    pipe1_d = '0;
    for (int k = 0; k < 3; k++) begin
      pipe1_d.p[k] = pt_t'(pin[k]) - pt_t'(cen[k]);
      z0 = C_W'(ang[k]) <<< (CORDIC_FRAC - ANGLE_FRAC);
      priority if (z0 > PI_Q30) begin
        pipe1_d.lane[k].z = z0 - TWO_PI_Q30;
      end else if (z0 < -PI_Q30) begin
        pipe1_d.lane[k].z = z0 + TWO_PI_Q30;
      end else begin
        pipe1_d.lane[k].z = z0;
      end
    end
  end

  // Fold into the right half plane and seed x with the CORDIC gain
  always_comb begin
    logic signed [C_W-1:0] z;
    pipe2_d = pipe1_q;
    for (int k = 0; k < 3; k++) begin
      z = pipe1_q.lane[k].z;
      pipe2_d.lane[k].x = GAIN_Q30;
      pipe2_d.lane[k].y = '0;
      priority if (z > HALF_PI_Q30) begin
        pipe2_d.lane[k].z   = z - PI_Q30;
        pipe2_d.lane[k].neg = 1'b1;
      end else if (z < -HALF_PI_Q30) begin
        pipe2_d.lane[k].z   = z + PI_Q30;
        pipe2_d.lane[k].neg = 1'b1;
      end else begin
        pipe2_d.lane[k].z   = z;
        pipe2_d.lane[k].neg = 1'b0;
      end
    end
  end

  // A stage takes a transaction when empty or when its successor advances
  assign rdy1    = ~v1_q | rdy2;
  assign rdy2    = ~v2_q | ready_i;
  assign ready_o = rdy1;
  assign valid_o = v2_q;
  assign data_o  = pipe2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) pipe1_q <= pipe1_d;
    if (rdy2 && v1_q)    pipe2_q <= pipe2_d;
  end

endmodule

### src/erot_cordic_cell.sv
// ----------------------------------------------------------------------------
// erot_cordic_cell: one CORDIC micro-rotation on three lanes
// Rotate each lane by +-atan(2^-step) towards zero residual angle and pass
// the point coordinates along unchanged.
// ----------------------------------------------------------------------------
module erot_cordic_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [erot_pkg::STEP_W-1:0]   step_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  erot_pkg::pipe_t               data_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output erot_pkg::pipe_t               data_o
);
  import erot_pkg::*;

  logic  valid_q;
  pipe_t cell_d, cell_q;

  // Micro-rotation, direction from the sign of the residual angle
  always_comb begin
    logic signed [C_W-1:0] xs;
    logic signed [C_W-1:0] ys;
    logic signed [C_W-1:0] at;
    cell_d = data_i;
    at     = C_W'(ATAN_Q30[step_i]);
    for (int k = 0; k < 3; k++) begin
      xs = data_i.lane[k].x >>> step_i;
      ys = data_i.lane[k].y >>> step_i;
      if (!data_i.lane[k].z[C_W-1]) begin
        cell_d.lane[k].x = data_i.lane[k].x - ys;
        cell_d.lane[k].y = data_i.lane[k].y + xs;
        cell_d.lane[k].z = data_i.lane[k].z - at;
      end else begin
        cell_d.lane[k].x = data_i.lane[k].x + ys;
        cell_d.lane[k].y = data_i.lane[k].y - xs;
        cell_d.lane[k].z = data_i.lane[k].z + at;
      end
    end
  end

  assign ready_o = ~valid_q | ready_i;
  assign valid_o = valid_q;
  assign data_o  = cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) cell_q <= cell_d;
  end

endmodule

### src/erot_rotate_cell.sv
// ----------------------------------------------------------------------------
// erot_rotate_cell: rotation of the point about one axis
// Round the axis' cosine and sine to Q24, form the four products, then sum
// and round them back to Q8 and write the two affected coordinates.
// ----------------------------------------------------------------------------
module erot_rotate_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  erot_pkg::axis_e axis_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  erot_pkg::pipe_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output erot_pkg::pipe_t data_o
);
  import erot_pkg::*;

  localparam logic signed [C_W-1:0]   SC_HALF  =
      C_W'(1) <<< (CORDIC_FRAC - SC_FRAC - 1);
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (SC_FRAC - 1);

  logic [1:0] ai, ui, vi;
  logic       va_q, vb_q, vc_q;
  logic       rdya, rdyb, rdyc;

  pipe_t                    pa_q, pb_q, pc_q, pc_d;
  logic signed [SC_W-1:0]   cos_d, sin_d, cos_q, sin_q;
  logic signed [PROD_W-1:0] cu_d, sv_d, su_d, cv_d;
  logic signed [PROD_W-1:0] cu_q, sv_q, su_q, cv_q;

  // Round a Q30 CORDIC output to Q24 and undo the fold
  function automatic logic signed [SC_W-1:0] round_sc(
    input logic signed [C_W-1:0] v,
    input logic                  neg
  );
    logic signed [C_W-1:0]  t;
    logic signed [SC_W-1:0] r;
    t = (v + SC_HALF) >>> (CORDIC_FRAC - SC_FRAC);
    r = SC_W'(t);
    return neg ? -r : r;
  endfunction

  // Lane of this axis and the coordinate pair it turns
  always_comb begin
    unique case (axis_i)
      AXIS_X: begin ai = 2'd0; ui = 2'd1; vi = 2'd2; end
      AXIS_Y: begin ai = 2'd1; ui = 2'd2; vi = 2'd0; end
      AXIS_Z: begin ai = 2'd2; ui = 2'd0; vi = 2'd1; end
      default: begin ai = 2'd0; ui = 2'd1; vi = 2'd2; end
    endcase
  end

  // Stage A: cosine and sine of this axis
  assign cos_d = round_sc(data_i.lane[ai].x, data_i.lane[ai].neg);
  assign sin_d = round_sc(data_i.lane[ai].y, data_i.lane[ai].neg);

  // Stage B: products
  always_comb begin
    pt_t u, v;
    u    = pa_q.p[ui];
    v    = pa_q.p[vi];
    cu_d = PROD_W'(cos_q) * PROD_W'(u);
    sv_d = PROD_W'(sin_q) * PROD_W'(v);
    su_d = PROD_W'(sin_q) * PROD_W'(u);
    cv_d = PROD_W'(cos_q) * PROD_W'(v);
  end

  // Stage C: sum and round to Q8
  always_comb begin
    logic signed [SUM_W-1:0] su, sv;
    su = (SUM_W'(cu_q) - SUM_W'(sv_q) + RND_HALF) >>> SC_FRAC;
    sv = (SUM_W'(su_q) + SUM_W'(cv_q) + RND_HALF) >>> SC_FRAC;
    pc_d       = pb_q;
    pc_d.p[ui] = pt_t'(su);
    pc_d.p[vi] = pt_t'(sv);
  end

  assign rdya    = ~va_q | rdyb;
  assign rdyb    = ~vb_q | rdyc;
  assign rdyc    = ~vc_q | ready_i;
  assign ready_o = rdya;
  assign valid_o = vc_q;
  assign data_o  = pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdya) va_q <= valid_i;
      if (rdyb) vb_q <= va_q;
      if (rdyc) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdya && valid_i) begin
      pa_q  <= data_i;
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
    if (rdyb && va_q) begin
      pb_q <= pa_q;
      cu_q <= cu_d;
      sv_q <= sv_d;
      su_q <= su_d;
      cv_q <= cv_d;
    end
    if (rdyc && vb_q) pc_q <= pc_d;
  end

endmodule

### src/erot_out.sv
// ----------------------------------------------------------------------------
// erot_out: output cell of the rotator
// Add the centre back, saturate each coordinate and hold the result in the
// output register until the transaction completes.
// ----------------------------------------------------------------------------
module erot_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  erot_pkg::cfg_t  cfg_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  erot_pkg::pipe_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output erot_pkg::out_t  data_o
);
  import erot_pkg::*;

  localparam logic signed [PT_W:0] SAT_HI =
      (PT_W + 1)'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [PT_W:0] SAT_LO = -SAT_HI - (PT_W + 1)'(1);

  logic   valid_q;
  out_t   out_d, out_q;
  coord_t res [3];

  // Centre add and saturation
  always_comb begin
    coord_t                cen [3];
    logic signed [PT_W:0]  s;
    cen = '{cfg_i.center_x, cfg_i.center_y, cfg_i.center_z};
    for (int k = 0; k < 3; k++) begin
      s = (PT_W + 1)'(data_i.p[k]) + (PT_W + 1)'(cen[k]);
      priority if (s > SAT_HI) begin
        res[k] = coord_t'(SAT_HI);
      end else if (s < SAT_LO) begin
        res[k] = coord_t'(SAT_LO);
      end else begin
        res[k] = coord_t'(s);
      end
    end
    out_d.out_x = res[0];
    out_d.out_y = res[1];
    out_d.out_z = res[2];
  end

  assign ready_o = ~valid_q | ready_i;
  assign valid_o = valid_q;
  assign data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) out_q <= out_d;
  end

endmodule

### src/erot_checker.sv
// ----------------------------------------------------------------------------
// erot_checker: port-level checks of the Euler point rotator
// Track transactions in flight and check output hold, occupancy bounds,
// minimum latency and reset behaviour.
// ----------------------------------------------------------------------------
module erot_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input erot_pkg::out_t out_data_o
);
  import erot_pkg::*;

  localparam int unsigned CNT_W = $clog2(PIPE_DEPTH + 1);

  logic             in_take, out_take;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign in_take  = in_valid_i & in_ready_o;
  assign out_take = out_valid_o & out_ready_i;

  // Count transactions in flight
  always_comb begin
    cnt_d = cnt_q;
    if (in_take && !out_take) cnt_d = cnt_q + CNT_W'(1);
    if (!in_take && out_take) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0)
    else $error("result offered with nothing in flight");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(PIPE_DEPTH))
    else $error("more transactions in flight than cells");

  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && cnt_q == '0 |=> !out_valid_o)
    else $error("result appeared one cycle after entry");

  // An edge seen in reset leaves the output register empty
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid after reset");

endmodule

bind euler_point_rotator_unit erot_checker u_erot_checker (.*);
